[rtl/divisor_enumerator_unit_defines.svh]
// Assertion macros for the divisor enumerator
`ifndef DIVISOR_ENUMERATOR_UNIT_DEFINES_SVH
`define DIVISOR_ENUMERATOR_UNIT_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define DEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define DEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/deu_pkg.sv]
// Shared types and constants for the divisor enumerator
package deu_pkg;

  localparam int NUM_W      = 12;
  localparam int COUNT_W    = 6;
  localparam int SCOUNT_W   = 7;
  localparam int SUM_W      = 14;
  localparam int PROD_W     = 32;
  localparam int PCOUNT_W   = 3;
  localparam int REM_CNT_W  = $clog2(NUM_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_TEST_WAIT,
    ST_PRIME,
    ST_PRIME_WAIT,
    ST_ACC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [NUM_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] rem;
  } rem_rsp_t;

endpackage

[rtl/deu_rem_unit.sv]
// Shared restoring remainder unit, one dividend bit per cycle
module deu_rem_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  deu_pkg::rem_req_t req_i,
  output deu_pkg::rem_rsp_t rsp_o
);
  import deu_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [REM_CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]     dvd_q, dvd_d;
  logic [NUM_W-1:0]     dvs_q, dvs_d;
  logic [NUM_W-1:0]     rem_q, rem_d;
  logic [NUM_W:0]       part;
  logic [NUM_W:0]       diff;

  always_comb begin
    part   = {rem_q, dvd_q[NUM_W-1]};
    diff   = part - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (part >= {1'b0, dvs_q}) ? diff[NUM_W-1:0] : part[NUM_W-1:0];
      dvd_d = {dvd_q[NUM_W-2:0], 1'b0};
      cnt_d = cnt_q + REM_CNT_W'(1);
      if (cnt_q == REM_CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

[rtl/divisor_enumerator_unit.sv]
// Each candidate divisibility test runs in the shared remainder unit.
// Each divisor then passes through an accumulate state and an emit state; emit holds while the output register is full.
// A divisor d >= 3 also adds up to (d - 2) trial tests in the same remainder unit.
// One item at a time: the input is ready only when the sequencer is idle.
// The output register frees the sequencer while the last result waits to be taken.
// Reset clears the sequencer and the output valid at once; no clearing pass.
module divisor_enumerator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [deu_pkg::NUM_W-1:0]      number_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [deu_pkg::NUM_W-1:0]      divisor_o,
  output logic                           divisor_is_prime_o,
  output logic                           last_o,
  output logic [deu_pkg::COUNT_W-1:0]    divisor_count_o,
  output logic [deu_pkg::SCOUNT_W-1:0]   signed_divisor_count_o,
  output logic [deu_pkg::SUM_W-1:0]      divisor_sum_o,
  output logic [deu_pkg::PROD_W-1:0]     divisor_product_o,
  output logic [deu_pkg::PCOUNT_W-1:0]   prime_divisor_count_o
);
  import deu_pkg::*;
  `include "divisor_enumerator_unit_defines.svh"

  state_e                state_q, state_d;
  logic [NUM_W-1:0]      n_q, n_d;
  logic [NUM_W-1:0]      cand_q, cand_d;
  logic [NUM_W-1:0]      trial_q, trial_d;
  logic                  prime_q, prime_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [PCOUNT_W-1:0]   pcount_q, pcount_d;

  logic                  out_valid_q, out_valid_d;
  logic [NUM_W-1:0]      out_div_q, out_div_d;
  logic                  out_prime_q, out_prime_d;
  logic                  out_last_q, out_last_d;
  logic [COUNT_W-1:0]    out_count_q, out_count_d;
  logic [SUM_W-1:0]      out_sum_q, out_sum_d;
  logic [PROD_W-1:0]     out_prod_q, out_prod_d;
  logic [PCOUNT_W-1:0]   out_pcount_q, out_pcount_d;

  logic                  out_load;
  logic                  is_last;
  logic [NUM_W-1:0]      trial_inc;
  rem_req_t              rem_req;
  rem_rsp_t              rem_rsp;

  deu_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    cand_d    = cand_q;
    trial_d   = trial_q;
    prime_d   = prime_q;
    count_d   = count_q;
    sum_d     = sum_q;
    prod_d    = prod_q;
    pcount_d  = pcount_q;
    in_ready_o = 1'b0;
    trial_inc = trial_q + NUM_W'(1);
    is_last   = (cand_q == n_q);
    out_load  = 1'b0;
    rem_req.start    = 1'b0;
    rem_req.dividend = n_q;
    rem_req.divisor  = cand_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          n_d      = number_i;
          cand_d   = NUM_W'(1);
          count_d  = '0;
          sum_d    = '0;
          prod_d   = PROD_W'(1);
          pcount_d = '0;
          if (number_i != '0) begin
            state_d = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        rem_req.start = 1'b1;
        state_d = ST_TEST_WAIT;
      end
      ST_TEST_WAIT: begin
        if (rem_rsp.done) begin
          if (rem_rsp.rem != '0) begin
            cand_d  = cand_q + NUM_W'(1);
            state_d = ST_TEST;
          end else if (cand_q < NUM_W'(2)) begin
            prime_d = 1'b0;
            state_d = ST_ACC;
          end else if (cand_q == NUM_W'(2)) begin
            prime_d = 1'b1;
            state_d = ST_ACC;
          end else begin
            trial_d = NUM_W'(2);
            state_d = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        rem_req.start    = 1'b1;
        rem_req.dividend = cand_q;
        rem_req.divisor  = trial_q;
        state_d = ST_PRIME_WAIT;
      end
      ST_PRIME_WAIT: begin
        if (rem_rsp.done) begin
          if (rem_rsp.rem == '0) begin
            prime_d = 1'b0;
            state_d = ST_ACC;
          end else if (trial_inc < cand_q) begin
            trial_d = trial_inc;
            state_d = ST_PRIME;
          end else begin
            trial_d = trial_inc;
            prime_d = 1'b1;
            state_d = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        count_d  = count_q + COUNT_W'(1);
        sum_d    = SUM_W'(sum_q + SUM_W'(cand_q));
        prod_d   = PROD_W'(prod_q * PROD_W'(cand_q));
        pcount_d = pcount_q + PCOUNT_W'(prime_q);
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        out_load = !out_valid_q || out_ready_i;
        if (out_load) begin
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            cand_d  = cand_q + NUM_W'(1);
            state_d = ST_TEST;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_div_d    = out_div_q;
    out_prime_d  = out_prime_q;
    out_last_d   = out_last_q;
    out_count_d  = out_count_q;
    out_sum_d    = out_sum_q;
    out_prod_d   = out_prod_q;
    out_pcount_d = out_pcount_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_div_d    = cand_q;
      out_prime_d  = prime_q;
      out_last_d   = is_last;
      out_count_d  = is_last ? count_q : '0;
      out_sum_d    = is_last ? sum_q : '0;
      out_prod_d   = is_last ? prod_q : '0;
      out_pcount_d = is_last ? pcount_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      cand_q      <= '0;
      trial_q     <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      prod_q      <= PROD_W'(1);
      pcount_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      cand_q      <= cand_d;
      trial_q     <= trial_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      prod_q      <= prod_d;
      pcount_q    <= pcount_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prime_q      <= prime_d;
    out_div_q    <= out_div_d;
    out_prime_q  <= out_prime_d;
    out_last_q   <= out_last_d;
    out_count_q  <= out_count_d;
    out_sum_q    <= out_sum_d;
    out_prod_q   <= out_prod_d;
    out_pcount_q <= out_pcount_d;
  end

  assign out_valid_o            = out_valid_q;
  assign divisor_o              = out_div_q;
  assign divisor_is_prime_o     = out_prime_q;
  assign last_o                 = out_last_q;
  assign divisor_count_o        = out_count_q;
  assign signed_divisor_count_o = {out_count_q, 1'b0};
  assign divisor_sum_o          = out_sum_q;
  assign divisor_product_o      = out_prod_q;
  assign prime_divisor_count_o  = out_pcount_q;

  `DEU_ASSERT(a_done_when_waiting,
              !rem_rsp.done || state_q == ST_TEST_WAIT || state_q == ST_PRIME_WAIT,
              "remainder done outside a wait state")
  `DEU_ASSERT(a_trial_range,
              state_q != ST_PRIME_WAIT || (trial_q >= NUM_W'(2) && trial_q < cand_q),
              "trial factor out of range")
  `DEU_ASSERT_NEXT(a_last_ends_item, out_load && is_last,
                   state_q == ST_IDLE && out_valid_q && out_last_q,
                   "last transaction did not end the item")

endmodule
